// ----- hdl/int32_to_decimal_ascii_unit_macros.svh -----
// ----------------------------------------------------------------------------
// int32 to decimal ascii assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in rst
// ----------------------------------------------------------------------------
`ifndef INT32_TO_DECIMAL_ASCII_UNIT_MACROS_SVH
`define INT32_TO_DECIMAL_ASCII_UNIT_MACROS_SVH

// same-cycle implication
`define I2DA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("i2da assertion failed");

// next-cycle implication
`define I2DA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("i2da assertion failed");

`endif

// ----- hdl/i2da_pkg.sv -----
// ----------------------------------------------------------------------------
// i2da_pkg
// shared types and constants of the int32 to decimal ascii unit
// ----------------------------------------------------------------------------
`default_nettype none

package i2da_pkg;

  localparam int MAG_W      = 32;
  localparam int NUM_DIGITS = 10;
  localparam int DIGIT_W    = 4;
  localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
  localparam int CNT_W      = $clog2(MAG_W);
  localparam int IDX_W      = $clog2(NUM_DIGITS);
  localparam int CHAR_W     = 8;

  localparam logic [CNT_W-1:0]   LAST_STEP    = CNT_W'(MAG_W - 1);
  localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
  localparam logic [DIGIT_W-1:0] DABBLE_ADJ   = 4'd3;
  localparam logic [CHAR_W-1:0]  ASCII_ZERO   = 8'd48;
  localparam logic [CHAR_W-1:0]  ASCII_MINUS  = 8'd45;
  localparam logic [CHAR_W-1:0]  ASCII_NINE   = 8'd57;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_HAND
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic hand;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_step;
    logic emit_free;
  } ctrl_status_t;

endpackage

`default_nettype wire

// ----- hdl/i2da_ctrl.sv -----
// ----------------------------------------------------------------------------
// i2da_ctrl
// sequencer for load, 32 shift-add steps and handoff to the emitter
// ----------------------------------------------------------------------------
`default_nettype none

module i2da_ctrl import i2da_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         value_valid,
  input  wire ctrl_status_t status,
  output logic              value_ready,
  output ctrl_cmd_t         cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (value_valid) state_next = ST_CONV;
      end
      ST_CONV: begin
        if (status.last_step) state_next = ST_HAND;
      end
      ST_HAND: begin
        if (status.emit_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    value_ready = 1'b0;
    cmd         = '0;
    case (state)
      ST_IDLE: begin
        // no request taken while reset is held
        value_ready = !rst;
        cmd.load    = value_valid && !rst;
      end
      ST_CONV: begin
        cmd.step = 1'b1;
      end
      ST_HAND: begin
        cmd.hand = status.emit_free;
      end
      default: begin
        value_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/i2da_dpath.sv -----
// ----------------------------------------------------------------------------
// i2da_dpath
// magnitude register and bit-serial double-dabble bcd converter
// ----------------------------------------------------------------------------
`default_nettype none

module i2da_dpath import i2da_pkg::*; (
  input  wire logic               clk,
  input  wire logic [MAG_W-1:0]   value,
  input  wire ctrl_cmd_t          cmd,
  output logic                    last_step,
  output logic                    neg,
  output logic [BCD_W-1:0]        bcd
);

  logic [MAG_W-1:0] mag;
  logic [CNT_W-1:0] cnt;
  logic [BCD_W-1:0] bcd_adj;

  // add three to every digit of five or more before the shift
  always_comb begin
    logic [DIGIT_W-1:0] nib;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      nib = bcd[i*DIGIT_W +: DIGIT_W];
      bcd_adj[i*DIGIT_W +: DIGIT_W] = (nib >= DABBLE_LIMIT) ? nib + DABBLE_ADJ : nib;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg <= value[MAG_W-1];
      mag <= value[MAG_W-1] ? (MAG_W'(0) - value) : value;
      bcd <= '0;
      cnt <= '0;
    end else if (cmd.step) begin
      {bcd, mag} <= {bcd_adj[BCD_W-2:0], mag, 1'b0};
      cnt        <= cnt + 1'b1;
    end
  end

  assign last_step = (cnt == LAST_STEP);

endmodule

`default_nettype wire

// ----- hdl/i2da_emit.sv -----
// ----------------------------------------------------------------------------
// i2da_emit
// character buffer: holds one converted number and sends its text
// ----------------------------------------------------------------------------
`default_nettype none

module i2da_emit import i2da_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               hand,
  input  wire logic               neg,
  input  wire logic [BCD_W-1:0]   bcd,
  output logic                    emit_free,
  output logic                    char_valid,
  input  wire logic               char_ready,
  output logic [CHAR_W-1:0]       char_code,
  output logic                    last_char
);

  logic                busy;
  logic                show_minus;
  logic [IDX_W-1:0]    idx;
  logic [IDX_W-1:0]    top;
  logic [DIGIT_W-1:0]  digit [NUM_DIGITS];
  logic                take;

  // highest nonzero digit, zero gives position 0
  always_comb begin
    top = '0;
    for (int i = 1; i < NUM_DIGITS; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] != '0) top = IDX_W'(i);
    end
  end

  assign take = busy && char_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      show_minus <= 1'b0;
    end else if (hand) begin
      busy       <= 1'b1;
      show_minus <= neg;
    end else if (take) begin
      if (show_minus) begin
        show_minus <= 1'b0;
      end else if (idx == '0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hand) begin
      idx <= top;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        digit[i] <= bcd[i*DIGIT_W +: DIGIT_W];
      end
    end else if (take && !show_minus && idx != '0) begin
      idx <= idx - 1'b1;
    end
  end

  assign emit_free  = !busy;
  assign char_valid = busy;
  assign char_code  = show_minus ? ASCII_MINUS : ASCII_ZERO + {4'd0, digit[idx]};
  assign last_char  = !show_minus && (idx == '0);

endmodule

`default_nettype wire

// ----- hdl/int32_to_decimal_ascii_unit.sv -----
// first character: follows the load, the 32 shift steps and the handoff, which waits for a free emit buffer
// requests: a new one is taken once the 32-step bit-serial bcd converter has handed off the last one,
//   and its conversion runs while the characters of the previous request drain from the emit buffer
// output: one character per cycle when char_ready is held high, 1 to 11 per request
// reset: synchronous active-high rst idles the sequencer and empties the emit buffer
// ----------------------------------------------------------------------------
// int32_to_decimal_ascii_unit
// signed 32-bit integer to decimal ascii text, most significant character first
// ----------------------------------------------------------------------------
`default_nettype none

`include "int32_to_decimal_ascii_unit_macros.svh"

module int32_to_decimal_ascii_unit import i2da_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // request channel
  input  wire logic                 value_valid,
  output logic                      value_ready,
  input  wire logic signed [31:0]   value,
  // character channel
  output logic                      char_valid,
  input  wire logic                 char_ready,
  output logic [7:0]                char_code,
  output logic                      last_char
);

  ctrl_cmd_t        cmd;
  ctrl_status_t     status;
  logic             last_step;
  logic             emit_free;
  logic             neg;
  logic [BCD_W-1:0] bcd;

  // status back to the sequencer
  assign status.last_step = last_step;
  assign status.emit_free = emit_free;

  // sequencer: idle, convert, hand off to the emit buffer
  i2da_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .value_valid (value_valid),
    .status      (status),
    .value_ready (value_ready),
    .cmd         (cmd)
  );

  // magnitude and bit-serial binary to bcd conversion
  i2da_dpath u_dpath (
    .clk       (clk),
    .value     (MAG_W'(value)),
    .cmd       (cmd),
    .last_step (last_step),
    .neg       (neg),
    .bcd       (bcd)
  );

  // emit buffer lets the next conversion run while text goes out
  i2da_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .hand       (cmd.hand),
    .neg        (neg),
    .bcd        (bcd),
    .emit_free  (emit_free),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_code  (char_code),
    .last_char  (last_char)
  );

  // a request starts a conversion, so no second request right behind it
  `I2DA_ASSERT_NEXT(a_busy_after_accept, value_valid && value_ready, !value_ready)

  // the minus sign never closes the text
  `I2DA_ASSERT_NOW(a_minus_not_last, char_valid && char_code == ASCII_MINUS, !last_char)

  // only minus or decimal digits leave the unit
  `I2DA_ASSERT_NOW(a_char_legal, char_valid,
    char_code == ASCII_MINUS || (char_code >= ASCII_ZERO && char_code <= ASCII_NINE))

endmodule

`default_nettype wire
